// ----- design/ffa_pkg.sv -----
// Shared widths, codes and types of the first-fit free list allocator.
`default_nettype none
package ffa_pkg;

  localparam int ADDR_W    = 24;
  localparam int LEN_W     = 25;
  localparam int SIZE_W    = 25;
  localparam int RND_W     = 26;
  localparam int STAT_W    = 2;
  localparam int TYPE_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 25;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int ALIGN_BYTES_DEF = 8;

  localparam logic [LEN_W-1:0] LEN_MAX      = 25'h1FF_FFFF;
  localparam logic [LEN_W-1:0] HEAP_TOP_RST = 25'h100_0000;

  localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_INIT  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_TOP  = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
  } entry_t;

endpackage
`default_nettype wire

// ----- design/ffa_if.sv -----
// Request and response channel interfaces of the allocator.
`default_nettype none
interface ffa_req_if;
  logic                        valid;
  logic                        ready;
  logic [ffa_pkg::TYPE_W-1:0]  req_type;
  logic [ffa_pkg::SIZE_W-1:0]  size_bytes;
  logic [ffa_pkg::ADDR_W-1:0]  block_addr;

  modport source (output valid, req_type, size_bytes, block_addr, input ready);
  modport sink   (input valid, req_type, size_bytes, block_addr, output ready);
endinterface

interface ffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ffa_pkg::STAT_W-1:0]  status;
  logic [ffa_pkg::ADDR_W-1:0]  alloc_addr;
  logic [ffa_pkg::LEN_W-1:0]   free_total;

  modport source (output valid, status, alloc_addr, free_total, input ready);
  modport sink   (input valid, status, alloc_addr, free_total, output ready);
endinterface
`default_nettype wire

// ----- design/first_fit_free_list_allocator.sv -----
// Top level of the first-fit free list allocator: control, config and output stage.
//
//   port      dir  handshake         payload
//   in_req    in   valid/ready       req_type, size_bytes, block_addr
//   out_rsp   out  valid/ready       status, alloc_addr, free_total
//   cfg_*     in   cfg_we            cfg_idx, cfg_wdata
//
// Init, rejected and unknown requests go straight to the output stage; free does the round-up
// by reciprocal multiply, then the push. Allocate does the round-up, then reads the list in
// order (one list read per cycle on the single read port) up to a hit or to no fit, and
// answers no fit on an empty list; an exact fit at position i > 0 then slides the entries
// ahead of it. Reset empties the list. A response held on out_rsp blocks
// only the completion of the next request.
`default_nettype none
module first_fit_free_list_allocator #(
  parameter int MAX_REGIONS = ffa_pkg::MAX_REGIONS_DEF,
  parameter int ALIGN_BYTES = ffa_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ffa_req_if.sink                             in_req,
  ffa_rsp_if.source                           out_rsp,
  input  wire logic                           cfg_we,
  input  wire logic [ffa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ffa_pkg::CFG_W-1:0]      cfg_wdata
);
  import ffa_pkg::*;

  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  typedef enum logic [2:0] {S_IDLE, S_ROUND, S_SCAN, S_MOVE, S_DONE} state_t;

  state_t               state_r, state_nxt;
  logic [TYPE_W-1:0]    type_r, type_nxt;
  logic [RND_W-1:0]     n_r, n_nxt;
  logic [ADDR_W-1:0]    baddr_r, baddr_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [LEN_W-1:0]     free_r, free_nxt;
  logic [CNT_W-1:0]     issue_r, issue_nxt;
  logic [CNT_W-1:0]     cmp_r, cmp_nxt;
  logic                 vld_r, vld_nxt;
  logic [CNT_W-1:0]     rj_r, rj_nxt;
  logic [CNT_W-1:0]     wj_r, wj_nxt;
  logic                 more_r, more_nxt;
  logic                 wvld_r, wvld_nxt;
  logic [STAT_W-1:0]    res_stat_r, res_stat_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_stat_r, out_stat_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [LEN_W-1:0]     out_free_r, out_free_nxt;
  logic [ADDR_W-1:0]    heap_base_r;
  logic [LEN_W-1:0]     heap_top_r;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  entry_t               rd_data;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  logic                 rnd_start;
  logic                 rnd_done;
  logic [RND_W-1:0]     rnd_n;

  logic [LEN_W-1:0]     push_len;
  logic [RND_W-1:0]     push_tot;
  logic [RND_W-1:0]     heap_span;
  logic [LEN_W-1:0]     take_free;
  logic [IDX_W-1:0]     head_dec;
  logic [IDX_W-1:0]     head_inc;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] i);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(h) + (CNT_W+1)'(i);
    if (s >= (CNT_W+1)'(MAX_REGIONS)) begin
      s = s - (CNT_W+1)'(MAX_REGIONS);
    end
    return s[IDX_W-1:0];
  endfunction

  ffa_mem #(.DEPTH(MAX_REGIONS), .IDX_W(IDX_W)) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffa_round #(.ALIGN_BYTES(ALIGN_BYTES)) u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (rnd_start),
    .size   (in_req.size_bytes),
    .done   (rnd_done),
    .result (rnd_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      heap_top_r  <= HEAP_TOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HEAP_BASE: heap_base_r <= cfg_wdata[ADDR_W-1:0];
        CFG_HEAP_TOP:  heap_top_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    push_len  = (rnd_n > RND_W'(LEN_MAX)) ? LEN_MAX : rnd_n[LEN_W-1:0];
    push_tot  = RND_W'(free_r) + RND_W'(push_len);
    heap_span = RND_W'(heap_top_r) - RND_W'(heap_base_r);
    take_free = (RND_W'(free_r) > n_r) ? free_r - n_r[LEN_W-1:0] : '0;
    head_dec  = (head_r == '0) ? IDX_W'(MAX_REGIONS - 1) : head_r - 1'b1;
    head_inc  = (head_r == IDX_W'(MAX_REGIONS - 1)) ? '0 : head_r + 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    type_nxt      = type_r;
    n_nxt         = n_r;
    baddr_nxt     = baddr_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    free_nxt      = free_r;
    issue_nxt     = issue_r;
    cmp_nxt       = cmp_r;
    vld_nxt       = vld_r;
    rj_nxt        = rj_r;
    wj_nxt        = wj_r;
    more_nxt      = more_r;
    wvld_nxt      = wvld_r;
    res_stat_nxt  = res_stat_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_stat_nxt  = out_stat_r;
    out_addr_nxt  = out_addr_r;
    out_free_nxt  = out_free_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rnd_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          type_nxt     = in_req.req_type;
          baddr_nxt    = in_req.block_addr;
          res_stat_nxt = ST_OK;
          res_addr_nxt = '0;
          state_nxt    = S_DONE;
          unique case (in_req.req_type)
            REQ_ALLOC: begin
              if (in_req.size_bytes == '0) begin
                res_stat_nxt = ST_NULL;
              end else begin
                rnd_start = 1'b1;
                state_nxt = S_ROUND;
              end
            end
            REQ_FREE: begin
              if (in_req.size_bytes == '0 || in_req.block_addr == '0) begin
                res_stat_nxt = ST_NULL;
              end else if (count_r == CNT_W'(MAX_REGIONS)) begin
                res_stat_nxt = ST_FULL;
              end else begin
                rnd_start = 1'b1;
                state_nxt = S_ROUND;
              end
            end
            REQ_INIT: begin
              if (RND_W'(heap_top_r) > RND_W'(heap_base_r)) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = '{addr: heap_base_r, len: heap_span[LEN_W-1:0]};
                head_nxt  = '0;
                count_nxt = CNT_W'(1);
                free_nxt  = heap_span[LEN_W-1:0];
              end else begin
                count_nxt = '0;
                free_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      S_ROUND: begin
        if (rnd_done) begin
          n_nxt = rnd_n;
          if (type_r == REQ_ALLOC) begin
            if (count_r == '0) begin
              res_stat_nxt = ST_NOFIT;
              state_nxt    = S_DONE;
            end else begin
              issue_nxt = '0;
              vld_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
          end else begin
            wr_en     = 1'b1;
            wr_addr   = head_dec;
            wr_data   = '{addr: baddr_r, len: push_len};
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
            free_nxt  = (push_tot > RND_W'(LEN_MAX)) ? LEN_MAX : push_tot[LEN_W-1:0];
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        if (issue_r < count_r) begin
          rd_en     = 1'b1;
          rd_addr   = phys(head_r, issue_r);
          cmp_nxt   = issue_r;
          vld_nxt   = 1'b1;
          issue_nxt = issue_r + 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
        if (vld_r) begin
          if (RND_W'(rd_data.len) == n_r) begin
            res_addr_nxt = rd_data.addr;
            free_nxt     = take_free;
            if (cmp_r == '0) begin
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              state_nxt = S_DONE;
            end else begin
              rj_nxt    = cmp_r - 1'b1;
              more_nxt  = 1'b1;
              wvld_nxt  = 1'b0;
              state_nxt = S_MOVE;
            end
          end else if (RND_W'(rd_data.len) > n_r) begin
            wr_en        = 1'b1;
            wr_addr      = phys(head_r, cmp_r);
            wr_data      = '{addr: rd_data.addr + n_r[ADDR_W-1:0],
                             len:  rd_data.len - n_r[LEN_W-1:0]};
            res_addr_nxt = rd_data.addr;
            free_nxt     = take_free;
            state_nxt    = S_DONE;
          end else if (cmp_r == count_r - 1'b1) begin
            res_stat_nxt = ST_NOFIT;
            state_nxt    = S_DONE;
          end
        end
      end

      S_MOVE: begin
        if (wvld_r) begin
          wr_en   = 1'b1;
          wr_addr = phys(head_r, wj_r);
          wr_data = rd_data;
        end
        if (more_r) begin
          rd_en    = 1'b1;
          rd_addr  = phys(head_r, rj_r);
          wvld_nxt = 1'b1;
          wj_nxt   = rj_r + 1'b1;
          if (rj_r == '0) begin
            more_nxt = 1'b0;
          end else begin
            rj_nxt = rj_r - 1'b1;
          end
        end else begin
          wvld_nxt = 1'b0;
          if (!wvld_r) begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_addr_nxt  = (res_stat_r == ST_OK) ? res_addr_r : '0;
          out_free_nxt  = free_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      free_r      <= '0;
      vld_r       <= 1'b0;
      more_r      <= 1'b0;
      wvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      free_r      <= free_nxt;
      vld_r       <= vld_nxt;
      more_r      <= more_nxt;
      wvld_r      <= wvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    type_r     <= type_nxt;
    n_r        <= n_nxt;
    baddr_r    <= baddr_nxt;
    issue_r    <= issue_nxt;
    cmp_r      <= cmp_nxt;
    rj_r       <= rj_nxt;
    wj_r       <= wj_nxt;
    res_stat_r <= res_stat_nxt;
    res_addr_r <= res_addr_nxt;
    out_stat_r <= out_stat_nxt;
    out_addr_r <= out_addr_nxt;
    out_free_r <= out_free_nxt;
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_stat_r;
  assign out_rsp.alloc_addr = out_addr_r;
  assign out_rsp.free_total = out_free_r;

endmodule
`default_nettype wire

// ----- design/ffa_round.sv -----
// Round-up of a size to the alignment unit by reciprocal multiply.
`default_nettype none
module ffa_round #(
  parameter int ALIGN_BYTES = ffa_pkg::ALIGN_BYTES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ffa_pkg::SIZE_W-1:0]  size,
  output logic                             done,
  output logic [ffa_pkg::RND_W-1:0]        result
);
  import ffa_pkg::*;

  localparam int     ALIGN_LOG  = $clog2(ALIGN_BYTES);
  localparam int     SHIFT      = RND_W + ALIGN_LOG;
  localparam int     RECIP_W    = RND_W + 1;
  localparam int     PROD_W     = RND_W + RECIP_W;
  localparam longint RECIP_FULL =
    ((longint'(1) << SHIFT) + longint'(ALIGN_BYTES - 1)) / longint'(ALIGN_BYTES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  logic               sum_vld_r, sum_vld_nxt;
  logic               quo_vld_r, quo_vld_nxt;
  logic               done_r, done_nxt;
  logic [RND_W-1:0]   v_r, v_nxt;
  logic [RND_W-1:0]   q_r, q_nxt;
  logic [RND_W-1:0]   res_r, res_nxt;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    prod        = PROD_W'(v_r) * PROD_W'(RECIP);
    sum_vld_nxt = start;
    quo_vld_nxt = sum_vld_r;
    done_nxt    = quo_vld_r;
    v_nxt       = start ? {1'b0, size} + RND_W'(ALIGN_BYTES - 1) : v_r;
    q_nxt       = sum_vld_r ? RND_W'(prod >> SHIFT) : q_r;
    res_nxt     = quo_vld_r ? q_r * RND_W'(ALIGN_BYTES) : res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
      quo_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      sum_vld_r <= sum_vld_nxt;
      quo_vld_r <= quo_vld_nxt;
      done_r    <= done_nxt;
    end
    v_r   <= v_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule
`default_nettype wire

// ----- design/ffa_mem.sv -----
// Region list storage: one write port, one registered read port.
`default_nettype none
module ffa_mem #(
  parameter int DEPTH = ffa_pkg::MAX_REGIONS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output ffa_pkg::entry_t        rd_data,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_addr,
  input  wire ffa_pkg::entry_t   wr_data
);
  import ffa_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire
